// File: rtl/core/axdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axdr_pkg
// Shared types, tag codes and the tag size lookup for the A-XDR row decoder.
// ----------------------------------------------------------------------------
package axdr_pkg;

   localparam logic [7:0] MAX_FIELDS_RESET = 8'd16;
   localparam logic [7:0] STRUCT_TAG       = 8'h02;

   // tag_size codes outside the byte counts
   localparam logic [7:0] SIZE_STRING  = 8'hFF;
   localparam logic [7:0] SIZE_UNKNOWN = 8'hFE;

   // DLMS type tags
   localparam logic [7:0] TAG_NULL     = 8'h00;
   localparam logic [7:0] TAG_BOOLEAN  = 8'h03;
   localparam logic [7:0] TAG_DLONG    = 8'h05;
   localparam logic [7:0] TAG_DLONG_U  = 8'h06;
   localparam logic [7:0] TAG_OCTETS   = 8'h09;
   localparam logic [7:0] TAG_VISIBLE  = 8'h0A;
   localparam logic [7:0] TAG_UTF8     = 8'h0C;
   localparam logic [7:0] TAG_BCD      = 8'h0D;
   localparam logic [7:0] TAG_INTEGER  = 8'h0F;
   localparam logic [7:0] TAG_LONG     = 8'h10;
   localparam logic [7:0] TAG_UNSIGNED = 8'h11;
   localparam logic [7:0] TAG_LONG_U   = 8'h12;
   localparam logic [7:0] TAG_LONG64   = 8'h14;
   localparam logic [7:0] TAG_LONG64_U = 8'h15;
   localparam logic [7:0] TAG_ENUM     = 8'h16;

   typedef enum logic [1:0] {
      ST_BUSY = 2'd0,
      ST_DONE = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       is_tag;
      logic [7:0] field_index;
      logic [7:0] row_count;
      status_type status;
   } rsp_item_type;

   // value bytes that follow a field tag
   function automatic logic [7:0] tag_size(input logic [7:0] tag);
      logic [7:0] size;
      unique case (tag)
         TAG_NULL:                                  size = 8'd0;
         TAG_BOOLEAN, TAG_BCD, TAG_INTEGER,
         TAG_UNSIGNED, TAG_ENUM:                    size = 8'd1;
         TAG_LONG, TAG_LONG_U:                      size = 8'd2;
         TAG_DLONG, TAG_DLONG_U:                    size = 8'd4;
         TAG_LONG64, TAG_LONG64_U:                  size = 8'd8;
         TAG_OCTETS, TAG_VISIBLE, TAG_UTF8:         size = SIZE_STRING;
         default:                                   size = SIZE_UNKNOWN;
      endcase
      return size;
   endfunction

endpackage

// File: rtl/core/axdr_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axdr_req_if
// Input byte channel: valid/ready handshake carrying one row byte per item.
// ----------------------------------------------------------------------------
interface axdr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_data;

   modport source (output valid, output in_byte, output end_of_data, input ready);
   modport sink   (input valid, input in_byte, input end_of_data, output ready);
endinterface

// File: rtl/core/axdr_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axdr_rsp_if
// Result channel: valid/ready handshake carrying one decoded item per byte.
// ----------------------------------------------------------------------------
interface axdr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_valid;
   logic       is_tag;
   logic [7:0] field_index;
   logic [7:0] row_count;
   logic [1:0] status;

   modport source (output valid, output out_byte, output out_valid, output is_tag,
                   output field_index, output row_count, output status, input ready);
   modport sink   (input valid, input out_byte, input out_valid, input is_tag,
                   input field_index, input row_count, input status, output ready);
endinterface

// File: rtl/core/axdr_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axdr_decode
// Row parser state and the per-byte decision; state moves on each step.
// ----------------------------------------------------------------------------
module axdr_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           in_byte,
   input  logic                 end_of_data,
   input  logic [7:0]           max_fields,
   output axdr_pkg::rsp_item_type result
);

   typedef enum logic [4:0] {
      PH_STAG  = 5'b00001,
      PH_COUNT = 5'b00010,
      PH_FTAG  = 5'b00100,
      PH_SLEN  = 5'b01000,
      PH_DATA  = 5'b10000   // fixed value bytes and string bytes
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] fields_left_ff, fields_left_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] current_field_ff, current_field_in;
   logic [7:0] header_count_ff, header_count_in;

   logic [7:0] size;
   logic [7:0] fields_dec;
   logic [7:0] bytes_dec;
   logic       end_fld;
   axdr_pkg::status_type status;

   always_comb begin
      phase_in         = phase_ff;
      fields_left_in   = fields_left_ff;
      bytes_left_in    = bytes_left_ff;
      current_field_in = current_field_ff;
      header_count_in  = header_count_ff;
      size             = axdr_pkg::tag_size(in_byte);
      fields_dec       = fields_left_ff - 8'd1;
      bytes_dec        = bytes_left_ff - 8'd1;
      end_fld          = 1'b0;
      status           = axdr_pkg::ST_BUSY;

      result.out_byte    = in_byte;
      result.out_valid   = 1'b0;
      result.is_tag      = 1'b0;
      result.field_index = 8'd0;

      unique case (phase_ff)
         PH_STAG: begin
            header_count_in = 8'd0;
            if (in_byte != axdr_pkg::STRUCT_TAG) begin
               status = axdr_pkg::ST_BAD;
            end else begin
               phase_in = PH_COUNT;
            end
         end
         PH_COUNT: begin
            header_count_in = in_byte;
            if (in_byte > max_fields) begin
               status = axdr_pkg::ST_BAD;
            end else if (in_byte == 8'd0) begin
               status = axdr_pkg::ST_DONE;
            end else begin
               fields_left_in   = in_byte;
               current_field_in = 8'd0;
               phase_in         = PH_FTAG;
            end
         end
         PH_FTAG: begin
            result.out_valid   = 1'b1;
            result.is_tag      = 1'b1;
            result.field_index = current_field_ff;
            if (size == axdr_pkg::SIZE_UNKNOWN) begin
               status = axdr_pkg::ST_BAD;
            end else if (size == axdr_pkg::SIZE_STRING) begin
               phase_in = PH_SLEN;
            end else if (size == 8'd0) begin
               end_fld = 1'b1;
            end else begin
               bytes_left_in = size;
               phase_in      = PH_DATA;
            end
         end
         PH_SLEN: begin
            result.out_valid   = 1'b1;
            result.field_index = current_field_ff;
            if (in_byte == 8'd0) begin
               end_fld = 1'b1;
            end else begin
               bytes_left_in = in_byte;
               phase_in      = PH_DATA;
            end
         end
         PH_DATA: begin
            result.out_valid   = 1'b1;
            result.field_index = current_field_ff;
            bytes_left_in      = bytes_dec;
            end_fld            = (bytes_dec == 8'd0);
         end
         default: begin
            phase_in = PH_STAG;
         end
      endcase

      // field closed: count it off, row done when none left
      if (end_fld) begin
         fields_left_in   = fields_dec;
         current_field_in = current_field_ff + 8'd1;
         if (fields_dec == 8'd0) begin
            status = axdr_pkg::ST_DONE;
         end else begin
            phase_in = PH_FTAG;
         end
      end

      // data ran out mid-row
      if (status == axdr_pkg::ST_BUSY && end_of_data) begin
         status = axdr_pkg::ST_BAD;
      end

      if (status != axdr_pkg::ST_BUSY) begin
         phase_in         = PH_STAG;
         fields_left_in   = 8'd0;
         bytes_left_in    = 8'd0;
         current_field_in = 8'd0;
      end

      result.row_count = header_count_in;
      result.status    = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_STAG;
         fields_left_ff   <= 8'd0;
         bytes_left_ff    <= 8'd0;
         current_field_ff <= 8'd0;
         header_count_ff  <= 8'd0;
      end else if (step) begin
         phase_ff         <= phase_in;
         fields_left_ff   <= fields_left_in;
         bytes_left_ff    <= bytes_left_in;
         current_field_ff <= current_field_in;
         header_count_ff  <= header_count_in;
      end
   end

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      step && result.status != axdr_pkg::ST_BUSY |=>
         phase_ff == PH_STAG && fields_left_ff == 8'd0 && current_field_ff == 8'd0)
      else $error("row end did not return to structure tag");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_COUNT && in_byte > max_fields |->
         result.status == axdr_pkg::ST_BAD)
      else $error("count over limit not flagged");

   a_end_of_data: assert property (@(posedge clock) disable iff (reset)
      step && end_of_data |-> result.status != axdr_pkg::ST_BUSY)
      else $error("end of data left row in progress");

   a_tag_is_field: assert property (@(posedge clock) disable iff (reset)
      result.is_tag |-> result.out_valid && phase_ff == PH_FTAG)
      else $error("tag flag outside field tag phase");

endmodule

// File: rtl/core/axdr_row_decoder_top.sv
`timescale 1ns / 1ps
// An accepted item is held in the input register, then moves to the output register once
// the output slot frees up. Throughput: one byte per cycle unless rsp ready stalls;
// req ready follows rsp ready in the same cycle once full. The parser state update is
// the registered loop that sets the rate. Reset (synchronous, active high) empties both
// registers, returns the parser to the structure tag and sets max_fields to 16.
// ----------------------------------------------------------------------------
// axdr_row_decoder_top
// A-XDR profile row decoder: byte stream in, one classified item out per byte.
// ----------------------------------------------------------------------------
module axdr_row_decoder_top (
   input  logic             clock,
   input  logic             reset,
   axdr_req_if.sink         req_ch,
   axdr_rsp_if.source       rsp_ch,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data
);

   // max_fields register; to be written only while idle, which the block does not enforce
   logic [7:0] max_fields_ff;

   // input register
   logic       in_full_ff, in_full_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // output register
   logic                   out_full_ff, out_full_in;
   axdr_pkg::rsp_item_type out_item_ff;

   axdr_pkg::rsp_item_type result;
   logic                   advance;
   logic                   req_take;

   // item moves from input to output register when the output slot frees up
   assign advance  = in_full_ff && (!out_full_ff || rsp_ch.ready);
   assign req_ch.ready = !in_full_ff || advance;
   assign req_take = req_ch.valid && req_ch.ready;

   always_comb begin
      in_full_in = in_full_ff;
      if (req_take) begin
         in_full_in = 1'b1;
      end else if (advance) begin
         in_full_in = 1'b0;
      end
      out_full_in = out_full_ff;
      if (advance) begin
         out_full_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_fields_ff <= axdr_pkg::MAX_FIELDS_RESET;
         in_full_ff    <= 1'b0;
         out_full_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_fields_ff <= csr_wr_data;
         end
         in_full_ff  <= in_full_in;
         out_full_ff <= out_full_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_ch.in_byte;
         in_last_ff <= req_ch.end_of_data;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   axdr_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .in_byte     (in_byte_ff),
      .end_of_data (in_last_ff),
      .max_fields  (max_fields_ff),
      .result      (result)
   );

   assign rsp_ch.valid       = out_full_ff;
   assign rsp_ch.out_byte    = out_item_ff.out_byte;
   assign rsp_ch.out_valid   = out_item_ff.out_valid;
   assign rsp_ch.is_tag      = out_item_ff.is_tag;
   assign rsp_ch.field_index = out_item_ff.field_index;
   assign rsp_ch.row_count   = out_item_ff.row_count;
   assign rsp_ch.status      = out_item_ff.status;

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      in_full_ff && out_full_ff && !rsp_ch.ready |-> !req_ch.ready)
      else $error("input taken while both registers full and stalled");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_full_ff)
      else $error("advanced item did not reach output register");

endmodule
